// ----- hdl/djt_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// djt_pkg
// shared types and constants for the deadline job timer table
// ---------------------------------------------------------------------------
package djt_pkg;

    // input modes
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_CANCEL = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_DONE   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ADD      = 2'd0;
    localparam logic [1:0] KIND_CANCEL   = 2'd1;
    localparam logic [1:0] KIND_DISPATCH = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    localparam int          MAX_RESULTS   = 16;
    localparam int          CNT_BITS      = $clog2(MAX_RESULTS + 1);
    localparam logic [7:0]  INFLIGHT_MAX  = 8'd255;
    localparam int          DELAY_BITS    = 32;
    localparam logic [31:0] MIN_DELAY_RST = 32'd10;

    typedef struct packed {
        logic [1:0]  mode;
        logic        is_periodic;
        logic [1:0]  job_priority;
        logic [31:0] delay_time;
        logic [47:0] now_time;
        logic [15:0] target_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] job_id;
        logic [1:0]  out_priority;
        logic        ok;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CANCEL_SCAN,
        ST_DONE_SCAN,
        ST_TICK_SCAN,
        ST_SERVE,
        ST_DIV_WAIT,
        ST_EMIT,
        ST_FINISH
    } state_t;

endpackage

// ----- hdl/deadline_job_timer_table.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deadline_job_timer_table
// table of deferred one-off and periodic jobs served by priority, then deadline, on ticks
// ---------------------------------------------------------------------------
// add goes straight to the finish state; cancel and done scan the slots until a match or the last slot
// tick: a full scan per served entry, each followed by a serve and an emit state,
//   then one final scan unless MAX_RESULTS were emitted; a periodic entry with
//   nonzero delay also waits in between for the shared restoring divider
// throughput: one item at a time, in_stall is high until the item is finished
// reset: table empty, in-flight counts zero, next id zero, min delay 10
module deadline_job_timer_table #(
    parameter int TABLE_ENTRIES   = 16,
    parameter int PRIORITY_LEVELS = 4,
    parameter int ID_BITS         = 16,
    parameter int TIME_BITS       = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  djt_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output djt_pkg::out_item_t  out_data
);

    localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(TABLE_ENTRIES - 1);

    // slot payload, written only on add and re-arm
    logic [ID_BITS-1:0]                  slot_id_mem  [TABLE_ENTRIES];
    logic [TIME_BITS-1:0]                slot_dl_mem  [TABLE_ENTRIES];
    logic [djt_pkg::DELAY_BITS-1:0]      slot_dly_mem [TABLE_ENTRIES];
    logic [1:0]                          slot_pri_mem [TABLE_ENTRIES];
    logic                                slot_per_mem [TABLE_ENTRIES];

    // control state
    djt_pkg::state_t            state_reg, state_next;
    logic [TABLE_ENTRIES-1:0]   valid_reg, valid_next;
    logic [TABLE_ENTRIES-1:0]   served_reg, served_next;
    logic [7:0]                 inflight_reg [TABLE_ENTRIES];
    logic [7:0]                 inflight_next [TABLE_ENTRIES];
    logic [ID_BITS-1:0]         next_id_reg, next_id_next;
    logic [31:0]                min_delay_reg;
    logic [IDX_BITS-1:0]        idx_reg, idx_next;
    logic [djt_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                       any_due_reg, any_due_next;

    // captured request
    logic [TIME_BITS-1:0]       now_reg, now_next;
    logic [ID_BITS-1:0]         tid_reg, tid_next;

    // best candidate of the current scan
    logic                       best_found_reg, best_found_next;
    logic [IDX_BITS-1:0]        best_idx_reg, best_idx_next;
    logic [1:0]                 best_pri_reg, best_pri_next;
    logic [TIME_BITS-1:0]       best_dl_reg, best_dl_next;
    logic [ID_BITS-1:0]         best_id_reg, best_id_next;
    logic [31:0]                best_dly_reg, best_dly_next;
    logic                       best_per_reg, best_per_next;
    logic [7:0]                 best_cnt_reg, best_cnt_next;

    // result staging: new -> pending -> output register
    djt_pkg::out_item_t         new_res_reg, new_res_next;
    logic                       has_new_reg, has_new_next;
    djt_pkg::out_item_t         pend_reg, pend_next;
    logic                       pend_valid_reg, pend_valid_next;
    djt_pkg::out_item_t         out_reg, out_next;
    logic                       out_valid_reg, out_valid_next;

    // payload write strobes
    logic                       add_we;
    logic [TIME_BITS-1:0]       add_dl;
    logic [1:0]                 add_pri;
    logic                       dl_we;
    logic [TIME_BITS-1:0]       dl_wdata;

    // shared divider
    logic                       div_start;
    logic                       div_busy;
    logic                       div_done;
    logic [TIME_BITS-1:0]       div_quo;
    logic [31:0]                div_rem;

    // helpers
    logic                       free_any;
    logic [IDX_BITS-1:0]        free_idx;
    logic                       out_free;
    logic                       in_accept;
    logic                       elig;
    logic                       better;
    logic                       q_hi;
    logic [9:0]                 q_sum;
    logic [7:0]                 rearm_cnt;

    djt_div #(
        .DIVIDEND_BITS (TIME_BITS),
        .DIVISOR_BITS  (djt_pkg::DELAY_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (now_reg - best_dl_reg),
        .divisor   (best_dly_reg),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // lowest free slot
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_BITS'(i);
            end
        end
    end

    // scan compare: strict, so the lower slot keeps a tie
    assign elig = valid_reg[idx_reg] && !served_reg[idx_reg] &&
                  (slot_dl_mem[idx_reg] <= now_reg);
    assign better = !best_found_reg || (slot_pri_mem[idx_reg] > best_pri_reg) ||
                    ((slot_pri_mem[idx_reg] == best_pri_reg) &&
                     (slot_dl_mem[idx_reg] < best_dl_reg));

    // in-flight saturation with the number of extra missed periods
    assign q_hi  = |(div_quo >> 8);
    assign q_sum = {2'b00, best_cnt_reg} + {2'b00, div_quo[7:0]} + 10'd1;

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        served_next     = served_reg;
        inflight_next   = inflight_reg;
        next_id_next    = next_id_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        any_due_next    = any_due_reg;
        now_next        = now_reg;
        tid_next        = tid_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_pri_next   = best_pri_reg;
        best_dl_next    = best_dl_reg;
        best_id_next    = best_id_reg;
        best_dly_next   = best_dly_reg;
        best_per_next   = best_per_reg;
        best_cnt_next   = best_cnt_reg;
        new_res_next    = new_res_reg;
        has_new_next    = has_new_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        add_we          = 1'b0;
        add_dl          = TIME_BITS'(in_data.now_time) + TIME_BITS'(in_data.delay_time);
        add_pri         = (int'(in_data.job_priority) >= PRIORITY_LEVELS)
                          ? 2'(PRIORITY_LEVELS - 1) : in_data.job_priority;
        dl_we           = 1'b0;
        dl_wdata        = now_reg - TIME_BITS'(div_rem) + TIME_BITS'(best_dly_reg);
        div_start       = 1'b0;
        rearm_cnt       = (q_hi || (q_sum >= 10'(djt_pkg::INFLIGHT_MAX)))
                          ? djt_pkg::INFLIGHT_MAX : q_sum[7:0];

        case (state_reg)
            djt_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    now_next = TIME_BITS'(in_data.now_time);
                    tid_next = ID_BITS'(in_data.target_id);
                    idx_next = '0;
                    case (in_data.mode)
                        djt_pkg::MODE_ADD:
                        begin
                            next_id_next = next_id_reg + 1'b1;
                            pend_next.kind         = djt_pkg::KIND_ADD;
                            pend_next.job_id       = 16'(next_id_reg);
                            pend_next.out_priority = 2'd0;
                            pend_next.ok           = 1'b0;
                            pend_next.last         = 1'b0;
                            if (!(in_data.is_periodic &&
                                  (in_data.delay_time < min_delay_reg)) && free_any)
                            begin
                                add_we                  = 1'b1;
                                valid_next[free_idx]    = 1'b1;
                                inflight_next[free_idx] = 8'd0;
                                pend_next.ok            = 1'b1;
                            end
                            pend_valid_next = 1'b1;
                            state_next      = djt_pkg::ST_FINISH;
                        end
                        djt_pkg::MODE_CANCEL:
                        begin
                            state_next = djt_pkg::ST_CANCEL_SCAN;
                        end
                        djt_pkg::MODE_DONE:
                        begin
                            state_next = djt_pkg::ST_DONE_SCAN;
                        end
                        default:
                        begin
                            served_next     = '0;
                            any_due_next    = 1'b0;
                            cnt_next        = '0;
                            best_found_next = 1'b0;
                            state_next      = djt_pkg::ST_TICK_SCAN;
                        end
                    endcase
                end
            end

            djt_pkg::ST_CANCEL_SCAN:
            begin
                pend_next.kind         = djt_pkg::KIND_CANCEL;
                pend_next.job_id       = 16'(tid_reg);
                pend_next.out_priority = 2'd0;
                pend_next.last         = 1'b0;
                if (valid_reg[idx_reg] && (slot_id_mem[idx_reg] == tid_reg))
                begin
                    valid_next[idx_reg]    = 1'b0;
                    inflight_next[idx_reg] = 8'd0;
                    pend_next.ok           = 1'b1;
                    pend_valid_next        = 1'b1;
                    state_next             = djt_pkg::ST_FINISH;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    pend_next.ok    = 1'b0;
                    pend_valid_next = 1'b1;
                    state_next      = djt_pkg::ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            djt_pkg::ST_DONE_SCAN:
            begin
                if (valid_reg[idx_reg] && slot_per_mem[idx_reg] &&
                    (slot_id_mem[idx_reg] == tid_reg))
                begin
                    if (inflight_reg[idx_reg] != 8'd0)
                    begin
                        inflight_next[idx_reg] = inflight_reg[idx_reg] - 8'd1;
                    end
                    state_next = djt_pkg::ST_FINISH;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    state_next = djt_pkg::ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            djt_pkg::ST_TICK_SCAN:
            begin
                if (elig && better)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = idx_reg;
                    best_pri_next   = slot_pri_mem[idx_reg];
                    best_dl_next    = slot_dl_mem[idx_reg];
                    best_id_next    = slot_id_mem[idx_reg];
                    best_dly_next   = slot_dly_mem[idx_reg];
                    best_per_next   = slot_per_mem[idx_reg];
                    best_cnt_next   = inflight_reg[idx_reg];
                end
                if (idx_reg == IDX_LAST)
                begin
                    if (best_found_next)
                    begin
                        state_next = djt_pkg::ST_SERVE;
                    end
                    else
                    begin
                        if (!any_due_reg)
                        begin
                            pend_next.kind         = djt_pkg::KIND_NONE;
                            pend_next.job_id       = 16'd0;
                            pend_next.out_priority = 2'd0;
                            pend_next.ok           = 1'b0;
                            pend_next.last         = 1'b0;
                            pend_valid_next        = 1'b1;
                        end
                        state_next = djt_pkg::ST_FINISH;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            djt_pkg::ST_SERVE:
            begin
                any_due_next               = 1'b1;
                served_next[best_idx_reg]  = 1'b1;
                new_res_next.kind          = djt_pkg::KIND_DISPATCH;
                new_res_next.job_id        = 16'(best_id_reg);
                new_res_next.out_priority  = best_pri_reg;
                new_res_next.ok            = 1'b1;
                new_res_next.last          = 1'b0;
                if (!best_per_reg)
                begin
                    has_new_next              = 1'b1;
                    valid_next[best_idx_reg]  = 1'b0;
                    state_next                = djt_pkg::ST_EMIT;
                end
                else
                begin
                    has_new_next = (best_cnt_reg == 8'd0);
                    if (best_dly_reg != 32'd0)
                    begin
                        div_start  = 1'b1;
                        state_next = djt_pkg::ST_DIV_WAIT;
                    end
                    else
                    begin
                        // zero period: deadline stays, one period counted
                        inflight_next[best_idx_reg] =
                            (best_cnt_reg == djt_pkg::INFLIGHT_MAX ||
                             best_cnt_reg == djt_pkg::INFLIGHT_MAX - 8'd1)
                            ? djt_pkg::INFLIGHT_MAX : best_cnt_reg + 8'd1;
                        state_next = djt_pkg::ST_EMIT;
                    end
                end
            end

            djt_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    dl_we                       = 1'b1;
                    inflight_next[best_idx_reg] = rearm_cnt;
                    state_next                  = djt_pkg::ST_EMIT;
                end
            end

            djt_pkg::ST_EMIT:
            begin
                if (!has_new_reg)
                begin
                    idx_next        = '0;
                    best_found_next = 1'b0;
                    state_next      = djt_pkg::ST_TICK_SCAN;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next       = pend_reg;
                        out_valid_next = 1'b1;
                    end
                    pend_next       = new_res_reg;
                    pend_valid_next = 1'b1;
                    has_new_next    = 1'b0;
                    cnt_next        = cnt_reg + 1'b1;
                    idx_next        = '0;
                    best_found_next = 1'b0;
                    if (cnt_reg == djt_pkg::CNT_BITS'(djt_pkg::MAX_RESULTS - 1))
                    begin
                        state_next = djt_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = djt_pkg::ST_TICK_SCAN;
                    end
                end
            end

            djt_pkg::ST_FINISH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = djt_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = djt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = djt_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= djt_pkg::ST_IDLE;
            valid_reg      <= '0;
            served_reg     <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                inflight_reg[i] <= 8'd0;
            end
            next_id_reg    <= '0;
            min_delay_reg  <= djt_pkg::MIN_DELAY_RST;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            any_due_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            has_new_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            served_reg     <= served_next;
            inflight_reg   <= inflight_next;
            next_id_reg    <= next_id_next;
            if (cfg_wr_en)
            begin
                min_delay_reg <= cfg_wr_data;
            end
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            any_due_reg    <= any_due_next;
            best_found_reg <= best_found_next;
            has_new_reg    <= has_new_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        tid_reg      <= tid_next;
        best_idx_reg <= best_idx_next;
        best_pri_reg <= best_pri_next;
        best_dl_reg  <= best_dl_next;
        best_id_reg  <= best_id_next;
        best_dly_reg <= best_dly_next;
        best_per_reg <= best_per_next;
        best_cnt_reg <= best_cnt_next;
        new_res_reg  <= new_res_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    // slot table writes
    always_ff @(posedge clk)
    begin
        if (add_we)
        begin
            slot_id_mem[free_idx]  <= next_id_reg;
            slot_dl_mem[free_idx]  <= add_dl;
            slot_dly_mem[free_idx] <= in_data.delay_time;
            slot_pri_mem[free_idx] <= add_pri;
            slot_per_mem[free_idx] <= in_data.is_periodic;
        end
        else if (dl_we)
        begin
            // re-arm one period past the last due deadline
            slot_dl_mem[best_idx_reg] <= dl_wdata;
        end
    end

    assign in_stall  = (state_reg != djt_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // nothing is left staged once the block is idle
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == djt_pkg::ST_IDLE) |-> !pend_valid_reg)
        else $error("pending result left while idle");

    // a tick never dispatches more than the result limit
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= djt_pkg::CNT_BITS'(djt_pkg::MAX_RESULTS))
        else $error("dispatch count past limit");

    // a nothing-due beat is always the last of its tick
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind == djt_pkg::KIND_NONE)) |-> out_reg.last)
        else $error("nothing-due beat without last");

    // the divider is only started when free
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

endmodule

// ----- hdl/djt_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// djt_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module djt_div #(
    parameter int DIVIDEND_BITS = 48,
    parameter int DIVISOR_BITS  = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     busy,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient,
    output logic [DIVISOR_BITS-1:0]  remainder
);

    localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] quo_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVISOR_BITS-1:0]  dsr_reg;
    logic [STEP_BITS-1:0]     step_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic [DIVISOR_BITS:0]    trial;
    logic                     fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_BITS'(DIVIDEND_BITS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_BITS-2:0], fits};
            rem_reg <= fits ? DIVISOR_BITS'(trial - {1'b0, dsr_reg})
                            : DIVISOR_BITS'(trial);
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
